FILE: hdl/ethtbl_pkg.sv
// Package for the ethertype handler table: table size, command and
// result beat types, cell entry and control structs. No dependencies.
package ethtbl_pkg;

  localparam int TABLE_ENTRIES = 16;   // 2 to 16
  localparam int SLOT_W        = 4;

  localparam logic [15:0] RESERVED_TYPE_MAX = 16'd1500;

  typedef enum logic [1:0] {
    ACT_LOOKUP,
    ACT_ATTACH,
    ACT_DETACH
  } action_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] ether_type;
    logic [31:0] handler_word;
  } cmd_t;

  typedef struct packed {
    logic              failed;
    logic              hit;
    logic [31:0]       handler_out;
    logic [SLOT_W-1:0] slot_index;
  } result_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] etype;
    logic [31:0] handler;
  } entry_t;

  typedef struct packed {
    logic        attach_go;
    logic        detach_go;
    logic [15:0] ether_type;
    logic [31:0] handler_word;
  } cell_ctl_t;

endpackage

FILE: hdl/ethtbl_cell.sv
// One slot of the handler table: holds an entry, compares it against the
// broadcast ethertype, loads a new entry on attach when first free and
// takes its upper neighbor's entry on detach. Depends on ethtbl_pkg.
module ethtbl_cell import ethtbl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  logic      prev_valid,
  input  logic      shift_in,
  input  entry_t    upper,
  output entry_t    ent,
  output logic      match,
  output logic      first_free,
  output logic      shift_out
);

  logic        valid;
  logic [15:0] etype;
  logic [31:0] handler;

  assign ent        = '{valid: valid, etype: etype, handler: handler};
  assign match      = valid && (etype == ctl.ether_type);
  assign first_free = !valid && prev_valid;
  // every slot at or above the detached one pulls its neighbor down
  assign shift_out  = shift_in || match;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.detach_go && shift_out) begin
      valid <= upper.valid;
    end else if (ctl.attach_go && first_free) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.detach_go && shift_out) begin
      etype   <= upper.etype;
      handler <= upper.handler;
    end else if (ctl.attach_go && first_free) begin
      etype   <= ctl.ether_type;
      handler <= ctl.handler_word;
    end
  end

endmodule

FILE: hdl/ethertype_handler_table.sv
// Ethertype handler table top level: command register, row of table cells,
// result encoding and the one-cycle result strobe. Depends on ethtbl_pkg.
// A command taken while idle loads the command register and sets busy; the
// result is then registered into rsp with done. Start is ignored while busy;
// compare and update across the cell row take the cycle after cmd is loaded.
// Reset clears all valid bits at once (empty table) and drops busy and done.
// The receiver cannot stall: done is high for exactly one cycle per command.
module ethertype_handler_table import ethtbl_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  cmd_t    req,
  output logic    busy,
  output logic    done,
  output result_t rsp
);

  cmd_t      cmd;
  cell_ctl_t ctl;
  result_t   rsp_next;

  entry_t                   ents   [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] match;
  logic [TABLE_ENTRIES-1:0] free1;
  logic [TABLE_ENTRIES:0]   shift;
  logic [TABLE_ENTRIES:0]   pvalid;

  logic              any_match;
  logic              full;
  logic              reserved;
  logic [31:0]       match_handler;
  logic [SLOT_W-1:0] match_slot;
  logic [SLOT_W-1:0] free_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= start && !busy;
      done <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd <= req;
    end
    if (busy) begin
      rsp <= rsp_next;
    end
  end

  assign shift[0]  = 1'b0;
  assign pvalid[0] = 1'b1;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    entry_t up;
    if (i == TABLE_ENTRIES - 1) begin : g_top
      assign up = '0;
    end else begin : g_mid
      assign up = ents[i+1];
    end

    ethtbl_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .prev_valid (pvalid[i]),
      .shift_in   (shift[i]),
      .upper      (up),
      .ent        (ents[i]),
      .match      (match[i]),
      .first_free (free1[i]),
      .shift_out  (shift[i+1])
    );
    assign pvalid[i+1] = ents[i].valid;
  end

  // match and first-free are one-hot at most: OR the selected slots together
  always_comb begin
    match_handler = '0;
    match_slot    = '0;
    free_slot     = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      match_handler = match_handler | (match[i] ? ents[i].handler : 32'd0);
      match_slot    = match_slot | (match[i] ? SLOT_W'(i) : '0);
      free_slot     = free_slot | (free1[i] ? SLOT_W'(i) : '0);
    end
  end

  assign any_match = |match;
  assign full      = ents[TABLE_ENTRIES-1].valid;
  assign reserved  = (cmd.ether_type != 16'd0) && (cmd.ether_type <= RESERVED_TYPE_MAX);

  always_comb begin
    ctl              = '0;
    ctl.ether_type   = cmd.ether_type;
    ctl.handler_word = cmd.handler_word;
    rsp_next.failed      = 1'b1;
    rsp_next.hit         = any_match;
    rsp_next.handler_out = '0;
    rsp_next.slot_index  = match_slot;
    unique case (cmd.action)
      ACT_LOOKUP: begin
        rsp_next.failed      = !any_match;
        rsp_next.handler_out = match_handler;
      end
      ACT_ATTACH: begin
        if (!reserved && !any_match && (cmd.handler_word != 32'd0) && !full) begin
          ctl.attach_go       = busy;
          rsp_next.failed     = 1'b0;
          rsp_next.slot_index = free_slot;
        end
      end
      ACT_DETACH: begin
        ctl.detach_go   = busy && any_match;
        rsp_next.failed = !any_match;
      end
      default: begin
        rsp_next.hit        = 1'b0;
        rsp_next.slot_index = '0;
      end
    endcase
  end

endmodule
